FILE: rtl/core/dpst_pkg.sv
// Shared constants, codes and controller/datapath handshake structs for the spanning tree core.
package dpst_pkg;

  localparam int VERTEX_BITS = 7;
  localparam int TOTAL_BITS  = 30;

  localparam logic [VERTEX_BITS-1:0] VCOUNT_RESET = 7'd64;

  localparam logic signed [TOTAL_BITS-1:0] TOTAL_MAX = {1'b0, {(TOTAL_BITS-1){1'b1}}};
  localparam logic signed [TOTAL_BITS-1:0] TOTAL_MIN = {1'b1, {(TOTAL_BITS-1){1'b0}}};

  // Request operation codes.
  localparam logic OP_ADD_EDGE = 1'b0;
  localparam logic OP_RUN      = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_TREE   = 2'd0;
  localparam logic [1:0] STATUS_DISC   = 2'd1;
  localparam logic [1:0] STATUS_SINGLE = 2'd2;

  typedef struct packed {
    logic item_ready;
    logic load_item;
    logic edge_rd;
    logic edge_wr1;
    logic edge_wr2;
    logic run_init;
    logic pass_step;
    logic emit_edge;
    logic emit_disc;
    logic emit_single;
    logic clear_step;
  } cmd_t;

  typedef struct packed {
    logic item_valid;
    logic item_run;
    logic edge_ok;
    logic need_write;
    logic n_one;
    logic pass_done;
    logic found;
    logic last_edge;
    logic out_free;
    logic clear_done;
  } sts_t;

endpackage

FILE: rtl/core/dpst_ifs.sv
// Request, result and configuration channel interfaces of the spanning tree core.
interface dpst_item_if #(parameter int WEIGHT_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [6:0]                    end_a;
  logic [6:0]                    end_b;
  logic signed [WEIGHT_BITS-1:0] weight;

  modport source (output valid, operation, end_a, end_b, weight, input ready);
  modport sink   (input valid, operation, end_a, end_b, weight, output ready);
endinterface

interface dpst_result_if #(parameter int WEIGHT_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic [6:0]                    parent_vertex;
  logic [6:0]                    child_vertex;
  logic signed [WEIGHT_BITS-1:0] edge_weight;
  logic signed [29:0]            total_weight;
  logic [1:0]                    status;
  logic                          last;

  modport source (output valid, parent_vertex, child_vertex, edge_weight, total_weight,
                  status, last, input ready);
  modport sink   (input valid, parent_vertex, child_vertex, edge_weight, total_weight,
                  status, last, output ready);
endinterface

interface dpst_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/core/dense_prim_spanning_tree_core.sv
// Edge load: a request is taken in idle, then steps through read, compare and, when needed, a
// second write, as one matrix write port serves both mirrored entries. Run: each tree vertex
// costs one pass over the n vertices (n = vertex count) plus a pick, then a sweep clears the matrix.
// Results leave through an output register; a stalled result holds the sequencer in place.
// Reset (synchronous, active high) starts the same clearing sweep, during which no request is
// taken; configuration writes are taken at any time.
module dense_prim_spanning_tree_core #(
  parameter int MAX_VERTICES = 64,
  parameter int WEIGHT_BITS  = 24
) (
  input  logic          clk,
  input  logic          rst,
  dpst_item_if.sink     item,
  dpst_result_if.source result,
  dpst_cfg_if.sink      cfg
);
  import dpst_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dpst_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  dpst_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sts    (sts),
    .item   (item),
    .result (result),
    .cfg    (cfg)
  );

endmodule

FILE: rtl/core/dpst_ram.sv
// Generic single write port, single read port RAM with registered read data.
module dpst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/dpst_ctrl.sv
// Sequencing state machine for edge loads, Prim passes, result emission and matrix clearing.
module dpst_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  dpst_pkg::sts_t sts,
  output dpst_pkg::cmd_t cmd
);
  import dpst_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_EDGE_RD   = 4'd1;
  localparam logic [3:0] S_EDGE_CMP  = 4'd2;
  localparam logic [3:0] S_EDGE_WR2  = 4'd3;
  localparam logic [3:0] S_RUN_INIT  = 4'd4;
  localparam logic [3:0] S_PASS      = 4'd5;
  localparam logic [3:0] S_PICK      = 4'd6;
  localparam logic [3:0] S_EMIT_DISC = 4'd7;
  localparam logic [3:0] S_EMIT_ONE  = 4'd8;
  localparam logic [3:0] S_CLEAR     = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      // The matrix is swept clear right after reset.
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.item_ready = 1'b1;
        if (sts.item_valid) begin
          cmd.load_item = 1'b1;
          state_next    = sts.item_run ? S_RUN_INIT : S_EDGE_RD;
        end
      end
      S_EDGE_RD: begin
        if (sts.edge_ok) begin
          cmd.edge_rd = 1'b1;
          state_next  = S_EDGE_CMP;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EDGE_CMP: begin
        if (sts.need_write) begin
          cmd.edge_wr1 = 1'b1;
          state_next   = S_EDGE_WR2;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EDGE_WR2: begin
        cmd.edge_wr2 = 1'b1;
        state_next   = S_IDLE;
      end
      S_RUN_INIT: begin
        cmd.run_init = 1'b1;
        state_next   = sts.n_one ? S_EMIT_ONE : S_PASS;
      end
      S_PASS: begin
        cmd.pass_step = 1'b1;
        if (sts.pass_done) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        if (!sts.found) begin
          state_next = S_EMIT_DISC;
        end else if (sts.out_free) begin
          cmd.emit_edge = 1'b1;
          state_next    = sts.last_edge ? S_CLEAR : S_PASS;
        end
      end
      S_EMIT_DISC: begin
        if (sts.out_free) begin
          cmd.emit_disc = 1'b1;
          state_next    = S_CLEAR;
        end
      end
      S_EMIT_ONE: begin
        if (sts.out_free) begin
          cmd.emit_single = 1'b1;
          state_next      = S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/dpst_datapath.sv
// Adjacency matrix, per-vertex distance store, relaxation/minimum pass and result register.
module dpst_datapath #(
  parameter int MAX_VERTICES = 64,
  parameter int WEIGHT_BITS  = 24
) (
  input  logic           clk,
  input  logic           rst,
  input  dpst_pkg::cmd_t cmd,
  output dpst_pkg::sts_t sts,
  dpst_item_if.sink      item,
  dpst_result_if.source  result,
  dpst_cfg_if.sink       cfg
);
  import dpst_pkg::*;

  localparam int VB = $clog2(MAX_VERTICES);
  localparam int MW = WEIGHT_BITS + 1;
  localparam int DW = WEIGHT_BITS + VB;
  localparam int SW = TOTAL_BITS + 4;
  localparam logic [VERTEX_BITS-1:0] VMAX = VERTEX_BITS'(MAX_VERTICES);

  // Configuration and captured request.
  logic [VERTEX_BITS-1:0]        vertex_count;
  logic [VB-1:0]                 ea;
  logic [VB-1:0]                 eb;
  logic signed [WEIGHT_BITS-1:0] w_in;
  logic                          edge_ok;

  // Run state.
  logic [VB:0]                   n;
  logic [VB-1:0]                 pick;
  logic [MAX_VERTICES-1:0]       in_tree;
  logic [MAX_VERTICES-1:0]       reached;
  logic signed [TOTAL_BITS-1:0]  sum;
  logic [VB:0]                   ecnt;
  logic [VB:0]                   vi;
  logic                          rd_valid;
  logic [VB-1:0]                 vd;
  logic                          found;
  logic [VB-1:0]                 best_v;
  logic signed [WEIGHT_BITS-1:0] best_d;
  logic [VB-1:0]                 best_p;
  logic [2*VB-1:0]               clr_addr;

  // Result register.
  logic                          out_valid;
  logic [VERTEX_BITS-1:0]        out_parent;
  logic [VERTEX_BITS-1:0]        out_child;
  logic signed [WEIGHT_BITS-1:0] out_weight;
  logic signed [TOTAL_BITS-1:0]  out_total;
  logic [1:0]                    out_status;
  logic                          out_last;

  // Memories.
  logic                          m_we;
  logic [2*VB-1:0]               m_waddr;
  logic [MW-1:0]                 m_wdata;
  logic [2*VB-1:0]               m_raddr;
  logic [MW-1:0]                 m_rdata;
  logic                          d_we;
  logic [DW-1:0]                 d_wdata;
  logic [DW-1:0]                 d_rdata;

  // Combinational helpers.
  logic [VERTEX_BITS-1:0]        a_m1;
  logic [VERTEX_BITS-1:0]        b_m1;
  logic                          item_edge_ok;
  logic [VB:0]                   n_clamp;
  logic signed [WEIGHT_BITS-1:0] m_w;
  logic                          m_present;
  logic signed [WEIGHT_BITS-1:0] cur_d;
  logic [VB-1:0]                 cur_p;
  logic                          upd;
  logic                          new_reached;
  logic signed [WEIGHT_BITS-1:0] new_d;
  logic [VB-1:0]                 new_p;
  logic                          cand;
  logic signed [SW-1:0]          sum_wide;
  logic signed [TOTAL_BITS-1:0]  sum_sat;
  logic [VB:0]                   ecnt_inc;
  logic                          out_load;

  dpst_ram #(.WIDTH(MW), .DEPTH(2 ** (2 * VB))) u_matrix (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  dpst_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_dist (
    .clk   (clk),
    .we    (d_we),
    .waddr (vd),
    .wdata (d_wdata),
    .raddr (vi[VB-1:0]),
    .rdata (d_rdata)
  );

  assign item.ready = cmd.item_ready;
  assign cfg.ready  = 1'b1;

  assign a_m1 = item.end_a - 7'd1;
  assign b_m1 = item.end_b - 7'd1;
  assign item_edge_ok = (item.end_a != '0) && (item.end_a <= VMAX) &&
                        (item.end_b != '0) && (item.end_b <= VMAX) &&
                        (item.end_a != item.end_b);

  always_comb begin
    if (vertex_count == '0) begin
      n_clamp = (VB+1)'(1);
    end else if (vertex_count > VMAX) begin
      n_clamp = (VB+1)'(MAX_VERTICES);
    end else begin
      n_clamp = vertex_count[VB:0];
    end
  end

  // Matrix entry is {present, weight}; the distance entry is {distance, parent}.
  assign m_present = m_rdata[MW-1];
  assign m_w       = m_rdata[WEIGHT_BITS-1:0];
  assign cur_d     = d_rdata[DW-1:VB];
  assign cur_p     = d_rdata[VB-1:0];

  // Relax vertex vd through the newest tree vertex, then fold it into the running minimum.
  assign upd         = !in_tree[vd] && m_present && (!reached[vd] || (cur_d > m_w));
  assign new_reached = reached[vd] || upd;
  assign new_d       = upd ? m_w : cur_d;
  assign new_p       = upd ? pick : cur_p;
  assign cand        = rd_valid && !in_tree[vd] && new_reached && (!found || (new_d < best_d));

  assign d_we    = rd_valid && upd;
  assign d_wdata = {new_d, new_p};

  always_comb begin
    m_we    = cmd.edge_wr1 || cmd.edge_wr2 || cmd.clear_step;
    m_wdata = cmd.clear_step ? '0 : {1'b1, w_in};
    if (cmd.clear_step) begin
      m_waddr = clr_addr;
    end else if (cmd.edge_wr1) begin
      m_waddr = {ea, eb};
    end else begin
      m_waddr = {eb, ea};
    end
    m_raddr = cmd.edge_rd ? {ea, eb} : {pick, vi[VB-1:0]};
  end

  assign sum_wide = SW'(sum) + SW'(best_d);
  always_comb begin
    if (sum_wide > SW'(TOTAL_MAX)) begin
      sum_sat = TOTAL_MAX;
    end else if (sum_wide < SW'(TOTAL_MIN)) begin
      sum_sat = TOTAL_MIN;
    end else begin
      sum_sat = sum_wide[TOTAL_BITS-1:0];
    end
  end

  assign ecnt_inc = ecnt + (VB+1)'(1);
  assign out_load = cmd.emit_edge || cmd.emit_disc || cmd.emit_single;

  always_comb begin
    sts            = '0;
    sts.item_valid = item.valid;
    sts.item_run   = (item.operation == OP_RUN);
    sts.edge_ok    = edge_ok;
    sts.need_write = !m_present || (w_in < m_w);
    sts.n_one      = (vertex_count <= 7'd1);
    sts.pass_done  = (vi == n) && !rd_valid;
    sts.found      = found;
    sts.last_edge  = (ecnt_inc == (n - (VB+1)'(1)));
    sts.out_free   = !out_valid || result.ready;
    sts.clear_done = &clr_addr;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCOUNT_RESET;
      in_tree      <= '0;
      reached      <= '0;
      sum          <= '0;
      ecnt         <= '0;
      vi           <= '0;
      rd_valid     <= 1'b0;
      found        <= 1'b0;
      clr_addr     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        vertex_count <= cfg.data;
      end
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + (2*VB)'(1);
      end
      if (cmd.run_init) begin
        in_tree  <= MAX_VERTICES'(1);
        reached  <= MAX_VERTICES'(1);
        sum      <= '0;
        ecnt     <= '0;
        vi       <= '0;
        rd_valid <= 1'b0;
        found    <= 1'b0;
      end
      if (cmd.pass_step) begin
        if (vi != n) begin
          vi       <= vi + (VB+1)'(1);
          rd_valid <= 1'b1;
        end else begin
          rd_valid <= 1'b0;
        end
      end
      if (rd_valid) begin
        reached[vd] <= new_reached;
        if (cand) begin
          found <= 1'b1;
        end
      end
      if (cmd.emit_edge) begin
        in_tree[best_v] <= 1'b1;
        sum             <= sum_sat;
        ecnt            <= ecnt_inc;
        vi              <= '0;
        rd_valid        <= 1'b0;
        found           <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      ea      <= a_m1[VB-1:0];
      eb      <= b_m1[VB-1:0];
      w_in    <= item.weight;
      edge_ok <= item_edge_ok;
    end
    if (cmd.run_init) begin
      n    <= n_clamp;
      pick <= '0;
    end
    if (cmd.pass_step && (vi != n)) begin
      vd <= vi[VB-1:0];
    end
    if (cand) begin
      best_v <= vd;
      best_d <= new_d;
      best_p <= new_p;
    end
    if (cmd.emit_edge) begin
      pick       <= best_v;
      out_parent <= VERTEX_BITS'(best_p) + 7'd1;
      out_child  <= VERTEX_BITS'(best_v) + 7'd1;
      out_weight <= best_d;
      out_total  <= sum_sat;
      out_status <= STATUS_TREE;
      out_last   <= sts.last_edge;
    end
    if (cmd.emit_disc) begin
      out_parent <= '0;
      out_child  <= '0;
      out_weight <= '0;
      out_total  <= sum;
      out_status <= STATUS_DISC;
      out_last   <= 1'b1;
    end
    if (cmd.emit_single) begin
      out_parent <= 7'd1;
      out_child  <= 7'd1;
      out_weight <= '0;
      out_total  <= '0;
      out_status <= STATUS_SINGLE;
      out_last   <= 1'b1;
    end
  end

  assign result.valid         = out_valid;
  assign result.parent_vertex = out_parent;
  assign result.child_vertex  = out_child;
  assign result.edge_weight   = out_weight;
  assign result.total_weight  = out_total;
  assign result.status        = out_status;
  assign result.last          = out_last;

endmodule

FILE: rtl/core/dpst_checker.sv
// Port-level checks on the result channel of the spanning tree core, bound to the top level.
module dpst_checker #(
  parameter int WEIGHT_BITS = 24
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          result_valid,
  input logic                          result_ready,
  input logic [6:0]                    parent_vertex,
  input logic [6:0]                    child_vertex,
  input logic signed [WEIGHT_BITS-1:0] edge_weight,
  input logic signed [29:0]            total_weight,
  input logic [1:0]                    status,
  input logic                          last
);
  import dpst_pkg::*;

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(parent_vertex) && $stable(child_vertex) &&
      $stable(edge_weight) && $stable(total_weight) && $stable(status) && $stable(last))
    else $error("result payload changed while stalled");

  a_disc_form: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == STATUS_DISC) |->
      last && (parent_vertex == 7'd0) && (child_vertex == 7'd0) && (edge_weight == '0))
    else $error("disconnected result malformed");

  a_single_form: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == STATUS_SINGLE) |->
      last && (total_weight == '0) && (parent_vertex == 7'd1) && (child_vertex == 7'd1))
    else $error("single vertex result malformed");

endmodule

bind dense_prim_spanning_tree_core dpst_checker #(.WEIGHT_BITS(WEIGHT_BITS)) u_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .parent_vertex (result.parent_vertex),
  .child_vertex  (result.child_vertex),
  .edge_weight   (result.edge_weight),
  .total_weight  (result.total_weight),
  .status        (result.status),
  .last          (result.last)
);

FILE: dv/dense_prim_spanning_tree_core_tb.sv
// Self-checking testbench for the dense Prim spanning tree core: edge loads, runs and vertex counts.
`timescale 1ns / 100ps

module dense_prim_spanning_tree_core_tb;
  import dpst_pkg::*;

  localparam int MAXV         = 64;
  localparam int WB           = 24;
  localparam int CLEAR_CYCLES = MAXV * MAXV + 200;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int ITEM_GOAL    = 250;

  typedef struct {
    logic                   op;
    logic [VERTEX_BITS-1:0] a;
    logic [VERTEX_BITS-1:0] b;
    logic signed [WB-1:0]   w;
    bit                     drain_first;
  } edge_req_t;

  typedef struct {
    logic [VERTEX_BITS-1:0]       parent;
    logic [VERTEX_BITS-1:0]       child;
    logic signed [WB-1:0]         wt;
    logic signed [TOTAL_BITS-1:0] total;
    logic [1:0]                   status;
    logic                         last;
  } span_edge_t;

  logic clk;
  logic rst;

  dpst_item_if #(.WEIGHT_BITS(WB))   item_ch ();
  dpst_result_if #(.WEIGHT_BITS(WB)) result_ch ();
  dpst_cfg_if                        cfg_ch ();

  dense_prim_spanning_tree_core #(
    .MAX_VERTICES(MAXV),
    .WEIGHT_BITS (WB)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch),
    .cfg   (cfg_ch)
  );

  edge_req_t              req_pending_q[$];
  span_edge_t             tree_expect_q[$];
  logic signed [WB-1:0]   adj_wt [MAXV][MAXV];
  bit                     adj_set [MAXV][MAXV];
  logic [VERTEX_BITS-1:0] model_vcount = VCOUNT_RESET;
  bit                     req_fire;
  bit                     cfg_fire;
  int unsigned            idle_pct = 14;
  int                     errors = 0;
  int                     tick = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor: keeps the lightest weight per vertex pair, both directions.
  function automatic void store_edge(logic [VERTEX_BITS-1:0] a, logic [VERTEX_BITS-1:0] b,
                                     logic signed [WB-1:0] w);
    int i;
    int j;
    i = int'(a) - 1;
    j = int'(b) - 1;
    if (i < 0 || i >= MAXV || j < 0 || j >= MAXV || i == j) return;
    if (!adj_set[i][j] || w < adj_wt[i][j]) begin
      adj_set[i][j] = 1'b1;
      adj_set[j][i] = 1'b1;
      adj_wt[i][j]  = w;
      adj_wt[j][i]  = w;
    end
  endfunction

  function automatic void expect_result(int p, int c, logic signed [WB-1:0] w, longint t,
                                        logic [1:0] st, logic l);
    span_edge_t r;
    r.parent = VERTEX_BITS'(p);
    r.child  = VERTEX_BITS'(c);
    r.wt     = w;
    r.total  = t[TOTAL_BITS-1:0];
    r.status = st;
    r.last   = l;
    tree_expect_q = {tree_expect_q, r};
  endfunction

  // Predictor: one tree edge per vertex joined, lowest vertex number wins a tie.
  function automatic void grow_tree();
    logic signed [WB-1:0] cand_wt [MAXV];
    int                   par [MAXV];
    bit                   joined [MAXV];
    bit                   seen [MAXV];
    logic signed [WB-1:0] d;
    longint               sum;
    int                   n;
    int                   pick;
    n = model_vcount;
    if (n < 1) n = 1;
    if (n > MAXV) n = MAXV;
    sum = 0;
    d = '0;
    if (n == 1) begin
      expect_result(1, 1, '0, 0, STATUS_SINGLE, 1'b1);
    end else begin
      for (int v = 0; v < MAXV; v++) begin
        joined[v]  = 1'b0;
        seen[v]    = 1'b0;
        cand_wt[v] = '0;
        par[v]     = 0;
      end
      joined[0] = 1'b1;
      seen[0]   = 1'b1;
      par[0]    = 1;
      for (int v = 1; v < n; v++) begin
        if (adj_set[0][v]) begin
          seen[v]    = 1'b1;
          cand_wt[v] = adj_wt[0][v];
          par[v]     = 1;
        end
      end
      for (int j = 0; j < n - 1; j++) begin
        pick = -1;
        for (int v = 0; v < n; v++) begin
          if (!joined[v] && seen[v] && (pick < 0 || cand_wt[v] < d)) begin
            pick = v;
            d    = cand_wt[v];
          end
        end
        if (pick < 0) begin
          expect_result(0, 0, '0, sum, STATUS_DISC, 1'b1);
          break;
        end
        joined[pick] = 1'b1;
        sum += d;
        if (sum > TOTAL_MAX) sum = TOTAL_MAX;
        if (sum < TOTAL_MIN) sum = TOTAL_MIN;
        expect_result(par[pick], pick + 1, d, sum, STATUS_TREE, j == n - 2);
        for (int v = 0; v < n; v++) begin
          if (!joined[v] && adj_set[pick][v] &&
              (!seen[v] || cand_wt[v] > adj_wt[pick][v])) begin
            seen[v]    = 1'b1;
            cand_wt[v] = adj_wt[pick][v];
            par[v]     = pick + 1;
          end
        end
      end
    end
    foreach (adj_set[i, k]) adj_set[i][k] = 1'b0;
  endfunction

  function automatic void compare_field(string name, logic signed [63:0] want,
                                        logic signed [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  // Monitor: predicts on every accepted request and checks every accepted result.
  always @(posedge clk) begin
    span_edge_t want;
    tick++;
    req_fire <= item_ch.valid && item_ch.ready;
    cfg_fire <= cfg_ch.valid && cfg_ch.ready;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) model_vcount = cfg_ch.data;
      if (item_ch.valid && item_ch.ready) begin
        if (item_ch.operation == OP_RUN) grow_tree();
        else store_edge(item_ch.end_a, item_ch.end_b, item_ch.weight);
      end
      if (result_ch.valid && result_ch.ready) begin
        if (tree_expect_q.size() == 0) begin
          errors++;
          $display("%0t: expected no result, got parent %0d child %0d weight %0d total %0d %s",
                   $time, result_ch.parent_vertex, result_ch.child_vertex,
                   result_ch.edge_weight, result_ch.total_weight,
                   $sformatf("status %0d last %0d", result_ch.status, result_ch.last));
        end else begin
          want = tree_expect_q.pop_front();
          compare_field("parent_vertex", want.parent, result_ch.parent_vertex);
          compare_field("child_vertex", want.child, result_ch.child_vertex);
          compare_field("edge_weight", want.wt, result_ch.edge_weight);
          compare_field("total_weight", want.total, result_ch.total_weight);
          compare_field("status", want.status, result_ch.status);
          compare_field("last", want.last, result_ch.last);
        end
      end
    end
    if (tick > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Driver: presents the next request after the current one has been taken.
  always @(negedge clk) begin
    edge_req_t nxt;
    if (rst) begin
      item_ch.valid   <= 1'b0;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= idle_pct);
      if (!item_ch.valid || req_fire) begin
        if (req_pending_q.size() != 0 &&
            !(req_pending_q[0].drain_first && tree_expect_q.size() != 0) &&
            $urandom_range(99) >= idle_pct) begin
          nxt = req_pending_q.pop_front();
          item_ch.valid     <= 1'b1;
          item_ch.operation <= nxt.op;
          item_ch.end_a     <= nxt.a;
          item_ch.end_b     <= nxt.b;
          item_ch.weight    <= nxt.w;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  function automatic logic signed [WB-1:0] rand_weight();
    int unsigned          r;
    logic signed [WB-1:0] w;
    r = $urandom_range(99);
    if (r < 45) w = WB'(int'($urandom_range(16)) - 8);
    else if (r < 85) w = WB'($urandom);
    else if (r < 93) w = {1'b0, {(WB-1){1'b1}}};
    else w = {1'b1, {(WB-1){1'b0}}};
    return w;
  endfunction

  // Returns 1 when the block will act on the request, 0 when it ignores it.
  function automatic int push_edge(int a, int b, int w);
    edge_req_t req;
    req.op          = OP_ADD_EDGE;
    req.a           = VERTEX_BITS'(a);
    req.b           = VERTEX_BITS'(b);
    req.w           = WB'(w);
    req.drain_first = ($urandom_range(29) == 0);
    req_pending_q   = {req_pending_q, req};
    return (a >= 1 && a <= MAXV && b >= 1 && b <= MAXV && a != b) ? 1 : 0;
  endfunction

  function automatic int push_run(bit drain);
    edge_req_t req;
    req.op          = OP_RUN;
    req.a           = VERTEX_BITS'($urandom);
    req.b           = VERTEX_BITS'($urandom);
    req.w           = WB'($urandom);
    req.drain_first = drain;
    req_pending_q   = {req_pending_q, req};
    return 1;
  endfunction

  // Mostly a random spanning tree over vertices 1..n plus extra and malformed edges,
  // in shuffled order, followed by a run.
  function automatic int queue_graph(int n);
    int order [MAXV];
    int ea[$];
    int eb[$];
    int cnt;
    int extra;
    int k;
    int t;
    int x;
    int y;
    cnt = 0;
    for (int i = 0; i < n; i++) order[i] = i + 1;
    for (int i = n - 1; i > 0; i--) begin
      k = $urandom_range(i);
      t = order[i];
      order[i] = order[k];
      order[k] = t;
    end
    if ($urandom_range(99) < 82) begin
      for (int i = 1; i < n; i++) begin
        ea = {ea, order[$urandom_range(i - 1)]};
        eb = {eb, order[i]};
      end
    end
    extra = (n > 20) ? $urandom_range(4) : $urandom_range(n + 2);
    for (int i = 0; i < extra; i++) begin
      x = $urandom_range(99);
      if (x < 70) begin
        ea = {ea, int'($urandom_range(n, 1))};
        eb = {eb, int'($urandom_range(n, 1))};
      end else if (x < 85) begin
        ea = {ea, int'(($urandom_range(3) == 0) ? 0 : $urandom_range(127, MAXV + 1))};
        eb = {eb, int'($urandom_range(MAXV, 1))};
      end else begin
        ea = {ea, int'($urandom_range(MAXV, 1))};
        eb = {eb, int'($urandom_range(MAXV, 1))};
      end
    end
    while (ea.size() > 0) begin
      k = $urandom_range(ea.size() - 1);
      x = ea[k];
      y = eb[k];
      ea.delete(k);
      eb.delete(k);
      if ($urandom_range(1)) cnt += push_edge(y, x, rand_weight());
      else cnt += push_edge(x, y, rand_weight());
    end
    cnt += push_run($urandom_range(7) == 0);
    return cnt;
  endfunction

  // Waits until every request is taken and every result is in, then lets the
  // matrix clearing sweep finish.
  task automatic settle();
    @(posedge clk);
    while (req_pending_q.size() != 0 || item_ch.valid || tree_expect_q.size() != 0)
      @(posedge clk);
    repeat (CLEAR_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_vcount(int v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= VERTEX_BITS'(v);
    @(negedge clk);
    while (!cfg_fire) @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int made;
    int phase;
    int cfg_val;
    int n;
    int unsigned r;
    item_ch.valid     = 1'b0;
    item_ch.operation = OP_ADD_EDGE;
    item_ch.end_a     = '0;
    item_ch.end_b     = '0;
    item_ch.weight    = '0;
    result_ch.ready   = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = VCOUNT_RESET;
    rst               = 1'b1;
    made              = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Full vertex count from reset: extreme weights, bad endpoints, self loop, duplicates.
    made += push_edge(1, 64, 8388607);
    made += push_edge(64, 2, -8388608);
    made += push_edge(0, 5, 1);
    made += push_edge(5, 0, 1);
    made += push_edge(65, 3, 1);
    made += push_edge(127, 127, -1);
    made += push_edge(3, 3, 7);
    made += push_edge(64, 1, 8388607);
    made += push_edge(64, 1, 100);
    made += push_edge(1, 64, 200);
    made += push_run(1'b0);
    // The matrix is empty now, so this run is disconnected at once.
    made += push_run(1'b1);
    settle();

    // A count of zero behaves as a single vertex.
    write_vcount(0);
    made += push_edge(1, 2, 5);
    made += push_run(1'b0);
    settle();
    write_vcount(1);
    made += push_run(1'b0);
    settle();

    // A count above the maximum behaves as the maximum.
    write_vcount(127);
    made += push_edge(63, 64, -1);
    made += push_edge(1, 63, 3);
    made += push_run(1'b0);
    settle();

    // Equal weights everywhere, plus an edge past the vertex count.
    write_vcount(4);
    made += push_edge(1, 3, 5);
    made += push_edge(1, 2, 5);
    made += push_edge(1, 4, 5);
    made += push_edge(2, 4, 5);
    made += push_edge(3, 5, -9);
    made += push_run(1'b0);
    settle();
    write_vcount(2);
    made += push_edge(2, 1, -8388608);
    made += push_run(1'b0);

    phase = 0;
    while (made < ITEM_GOAL) begin
      settle();
      if (phase == 3) begin
        cfg_val = MAXV;
      end else begin
        r = $urandom_range(99);
        if (r < 72) cfg_val = $urandom_range(8, 2);
        else if (r < 90) cfg_val = $urandom_range(20, 9);
        else if (r < 97) cfg_val = $urandom_range(1, 0);
        else cfg_val = $urandom_range(127, MAXV + 1);
      end
      write_vcount(cfg_val);
      n = (cfg_val < 1) ? 1 : (cfg_val > MAXV) ? MAXV : cfg_val;
      // One full-size phase runs with both sides never idling.
      idle_pct = (phase == 3) ? 0 : 14;
      repeat ($urandom_range(2, 1)) made += queue_graph(n);
      phase++;
    end
    settle();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
